// ===== design/ptpp_pkg.sv =====
// Shared types, constants and the tone pattern ROM of the tone pattern player.
package ptpp_pkg;

  localparam int ROM_DEPTH   = 64;
  localparam int MAX_STEPS   = 16;
  localparam int NUM_EFFECTS = 11;
  localparam int ROM_WORDS   = 52;

  localparam int HZ_W     = 15;
  localparam int MS_W     = 8;
  localparam int EFFECT_W = 4;
  localparam int STEP_W   = 4;
  localparam int REQ_W    = 2;
  localparam int ADDR_W   = 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK = 2'd0,
    REQ_PLAY = 2'd1,
    REQ_STOP = 2'd2,
    REQ_NOP  = 2'd3
  } req_kind_t;

  typedef struct packed {
    logic [HZ_W-1:0] hz;
    logic [MS_W-1:0] ms;
  } tone_step_t;

  typedef struct packed {
    logic                valid;
    logic [REQ_W-1:0]    req_type;
    logic [EFFECT_W-1:0] effect_id;
  } stage_t;

  function automatic logic [ADDR_W-1:0] effect_base(input logic [EFFECT_W-1:0] effect);
    logic [ADDR_W-1:0] base;
    case (effect)
      4'd2:    base = 8'd4;
      4'd3:    base = 8'd8;
      4'd4:    base = 8'd14;
      4'd5:    base = 8'd20;
      4'd6:    base = 8'd26;
      4'd7:    base = 8'd28;
      4'd8:    base = 8'd31;
      4'd9:    base = 8'd33;
      4'd10:   base = 8'd43;
      4'd11:   base = 8'd49;
      default: base = 8'd0;
    endcase
    return base;
  endfunction

  function automatic tone_step_t rom_word(input logic [ADDR_W-1:0] addr);
    tone_step_t w;
    case (addr)
      8'd0:    w = '{hz: 15'd1000, ms: 8'd10};
      8'd1:    w = '{hz: 15'd800,  ms: 8'd10};
      8'd2:    w = '{hz: 15'd600,  ms: 8'd10};
      8'd4:    w = '{hz: 15'd1200, ms: 8'd20};
      8'd5:    w = '{hz: 15'd0,    ms: 8'd20};
      8'd6:    w = '{hz: 15'd1200, ms: 8'd20};
      8'd8:    w = '{hz: 15'd200,  ms: 8'd25};
      8'd9:    w = '{hz: 15'd0,    ms: 8'd15};
      8'd10:   w = '{hz: 15'd150,  ms: 8'd25};
      8'd11:   w = '{hz: 15'd0,    ms: 8'd15};
      8'd12:   w = '{hz: 15'd100,  ms: 8'd25};
      8'd14:   w = '{hz: 15'd300,  ms: 8'd100};
      8'd15:   w = '{hz: 15'd250,  ms: 8'd100};
      8'd16:   w = '{hz: 15'd200,  ms: 8'd100};
      8'd17:   w = '{hz: 15'd150,  ms: 8'd100};
      8'd18:   w = '{hz: 15'd100,  ms: 8'd100};
      8'd20:   w = '{hz: 15'd440,  ms: 8'd30};
      8'd21:   w = '{hz: 15'd0,    ms: 8'd10};
      8'd22:   w = '{hz: 15'd554,  ms: 8'd30};
      8'd23:   w = '{hz: 15'd0,    ms: 8'd10};
      8'd24:   w = '{hz: 15'd659,  ms: 8'd30};
      8'd26:   w = '{hz: 15'd150,  ms: 8'd80};
      8'd28:   w = '{hz: 15'd100,  ms: 8'd15};
      8'd29:   w = '{hz: 15'd150,  ms: 8'd15};
      8'd31:   w = '{hz: 15'd880,  ms: 8'd15};
      8'd33:   w = '{hz: 15'd523,  ms: 8'd40};
      8'd34:   w = '{hz: 15'd0,    ms: 8'd30};
      8'd35:   w = '{hz: 15'd523,  ms: 8'd40};
      8'd36:   w = '{hz: 15'd0,    ms: 8'd30};
      8'd37:   w = '{hz: 15'd523,  ms: 8'd40};
      8'd38:   w = '{hz: 15'd0,    ms: 8'd30};
      8'd39:   w = '{hz: 15'd659,  ms: 8'd40};
      8'd40:   w = '{hz: 15'd0,    ms: 8'd30};
      8'd41:   w = '{hz: 15'd784,  ms: 8'd60};
      8'd43:   w = '{hz: 15'd200,  ms: 8'd200};
      8'd44:   w = '{hz: 15'd180,  ms: 8'd200};
      8'd45:   w = '{hz: 15'd160,  ms: 8'd200};
      8'd46:   w = '{hz: 15'd140,  ms: 8'd200};
      8'd47:   w = '{hz: 15'd120,  ms: 8'd200};
      8'd49:   w = '{hz: 15'd1000, ms: 8'd200};
      8'd50:   w = '{hz: 15'd500,  ms: 8'd200};
      default: w = '{hz: 15'd0,    ms: 8'd0};
    endcase
    return w;
  endfunction

  // Steps past the pattern limits read as a terminator.
  function automatic tone_step_t rom_fetch(input logic [EFFECT_W-1:0] effect,
                                           input logic [STEP_W:0]     step);
    logic [ADDR_W-1:0] addr;
    tone_step_t        w;
    addr = effect_base(effect) + ADDR_W'(step);
    w    = rom_word(addr);
    if ((effect == '0) || (effect > EFFECT_W'(NUM_EFFECTS)) ||
        (int'(step) >= MAX_STEPS) || (int'(step) > 15) ||
        (int'(addr) >= ROM_DEPTH) || (int'(addr) >= ROM_WORDS)) begin
      w = '{hz: '0, ms: '0};
    end
    return w;
  endfunction

endpackage

// ===== design/ptpp_if.sv =====
// Request and result channel interfaces of the tone pattern player.
interface ptpp_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [3:0] effect_id;

  modport source (output valid, output req_type, output effect_id, input ready);
  modport sink (input valid, input req_type, input effect_id, output ready);
endinterface

interface ptpp_res_if;
  logic        valid;
  logic        ready;
  logic [14:0] tone_hz;
  logic        tone_on;
  logic [3:0]  active_effect;
  logic [3:0]  step_index;

  modport source (output valid, output tone_hz, output tone_on, output active_effect,
                  output step_index, input ready);
  modport sink (input valid, input tone_hz, input tone_on, input active_effect,
                input step_index, output ready);
endinterface

// ===== design/ptpp_in_stage.sv =====
// Input register that captures one request transfer at a time.
module ptpp_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  ptpp_req_if.sink       in_req,
  input  logic           item_take,
  output ptpp_pkg::stage_t item
);
  import ptpp_pkg::*;

  stage_t item_r;
  stage_t item_nxt;

  assign in_req.ready = !item_r.valid || item_take;
  assign item         = item_r;

  always_comb begin
    item_nxt = item_r;
    if (in_req.valid && in_req.ready) begin
      item_nxt.valid     = 1'b1;
      item_nxt.req_type  = in_req.req_type;
      item_nxt.effect_id = in_req.effect_id;
    end else if (item_take) begin
      item_nxt.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.valid <= 1'b0;
    end else begin
      item_r.valid <= item_nxt.valid;
    end
    item_r.req_type  <= item_nxt.req_type;
    item_r.effect_id <= item_nxt.effect_id;
  end

endmodule

// ===== design/ptpp_engine.sv =====
// Player state, step sequencing against the tone ROM and the result register.
module ptpp_engine (
  input  logic             clk,
  input  logic             rst_n,
  input  ptpp_pkg::stage_t item,
  output logic             item_take,
  ptpp_res_if.source       out_res
);
  import ptpp_pkg::*;

  logic [EFFECT_W-1:0] effect_r, effect_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [MS_W-1:0]     elapsed_r, elapsed_nxt;
  logic [MS_W-1:0]     elapsed_inc;
  tone_step_t          cur_word, next_word, show_word;

  logic                out_valid_r;
  logic [HZ_W-1:0]     hz_r;
  logic                on_r;
  logic [EFFECT_W-1:0] active_r;
  logic [STEP_W-1:0]   index_r;

  assign item_take = item.valid && (!out_valid_r || out_res.ready);

  always_comb begin
    cur_word    = rom_fetch(effect_r, {1'b0, step_r});
    next_word   = rom_fetch(effect_r, {1'b0, step_r} + 5'd1);
    elapsed_inc = (elapsed_r != '1) ? elapsed_r + 8'd1 : elapsed_r;
    effect_nxt  = effect_r;
    step_nxt    = step_r;
    elapsed_nxt = elapsed_r;
    case (item.req_type)
      REQ_PLAY: begin
        if ((item.effect_id != '0) && (item.effect_id <= EFFECT_W'(NUM_EFFECTS)) &&
            !((effect_r != '0) && (item.effect_id > effect_r))) begin
          effect_nxt  = item.effect_id;
          step_nxt    = '0;
          elapsed_nxt = '0;
        end
      end
      REQ_STOP: begin
        effect_nxt  = '0;
        step_nxt    = '0;
        elapsed_nxt = '0;
      end
      REQ_TICK: begin
        if (effect_r != '0) begin
          elapsed_nxt = elapsed_inc;
          if (elapsed_inc >= cur_word.ms) begin
            if (next_word.ms == '0) begin
              effect_nxt  = '0;
              step_nxt    = '0;
              elapsed_nxt = '0;
            end else begin
              step_nxt    = step_r + 4'd1;
              elapsed_nxt = '0;
            end
          end
        end
      end
      default: begin
      end
    endcase
    show_word = rom_fetch(effect_nxt, {1'b0, step_nxt});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      effect_r    <= '0;
      step_r      <= '0;
      elapsed_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (item_take) begin
        effect_r    <= effect_nxt;
        step_r      <= step_nxt;
        elapsed_r   <= elapsed_nxt;
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      hz_r     <= (effect_nxt != '0) ? show_word.hz : '0;
      on_r     <= (effect_nxt != '0);
      active_r <= effect_nxt;
      index_r  <= step_nxt;
    end
  end

  assign out_res.valid         = out_valid_r;
  assign out_res.tone_hz       = hz_r;
  assign out_res.tone_on       = on_r;
  assign out_res.active_effect = active_r;
  assign out_res.step_index    = index_r;

endmodule

// ===== design/priority_tone_pattern_player_core.sv =====
// Top level of the priority tone pattern player.
//
// The in_req channel carries one request per transfer: a 1 ms tick, a play
// request with an effect id, a stop or a no-op. The out_res channel returns
// exactly one result per request, showing the buzzer frequency, whether an
// effect is sounding, the active effect and its step index after that request.
// A request is held in an input register and is processed, once the result
// register is free, by ROM lookups and compares, which write the result
// register. A request passes through the input register and then the result
// register before its result transfer. While the receiver keeps up, a new
// request can be taken in every cycle, so the throughput is one request per
// cycle. A new request is taken while a finished result still waits.
// When the receiver stalls, the result register holds its value and the
// input register fills, after which in_req.ready goes low until the result
// transfer happens. Reset returns the player to idle with no effect playing
// and empties both registers.
module priority_tone_pattern_player_core (
  input  logic        clk,
  input  logic        rst_n,
  ptpp_req_if.sink    in_req,
  ptpp_res_if.source  out_res
);
  import ptpp_pkg::*;

  stage_t item;
  logic   item_take;

  ptpp_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .item_take (item_take),
    .item      (item)
  );

  ptpp_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .item      (item),
    .item_take (item_take),
    .out_res   (out_res)
  );

endmodule

// ===== sim/priority_tone_pattern_player_core_tb.sv =====
// Self-checking testbench of the priority tone pattern player with a predictor and random stalls.
module priority_tone_pattern_player_core_tb;
  import ptpp_pkg::*;

  typedef struct packed {
    logic [HZ_W-1:0]     tone_hz;
    logic                tone_on;
    logic [EFFECT_W-1:0] active_effect;
    logic [STEP_W-1:0]   step_index;
  } tone_result_t;

  localparam logic [HZ_W+MS_W-1:0] PATTERN_ROM [0:ROM_WORDS-1] = '{
    {15'd1000, 8'd10}, {15'd800, 8'd10}, {15'd600, 8'd10}, {15'd0, 8'd0},
    {15'd1200, 8'd20}, {15'd0, 8'd20}, {15'd1200, 8'd20}, {15'd0, 8'd0},
    {15'd200, 8'd25}, {15'd0, 8'd15}, {15'd150, 8'd25}, {15'd0, 8'd15},
    {15'd100, 8'd25}, {15'd0, 8'd0},
    {15'd300, 8'd100}, {15'd250, 8'd100}, {15'd200, 8'd100}, {15'd150, 8'd100},
    {15'd100, 8'd100}, {15'd0, 8'd0},
    {15'd440, 8'd30}, {15'd0, 8'd10}, {15'd554, 8'd30}, {15'd0, 8'd10},
    {15'd659, 8'd30}, {15'd0, 8'd0},
    {15'd150, 8'd80}, {15'd0, 8'd0},
    {15'd100, 8'd15}, {15'd150, 8'd15}, {15'd0, 8'd0},
    {15'd880, 8'd15}, {15'd0, 8'd0},
    {15'd523, 8'd40}, {15'd0, 8'd30}, {15'd523, 8'd40}, {15'd0, 8'd30},
    {15'd523, 8'd40}, {15'd0, 8'd30}, {15'd659, 8'd40}, {15'd0, 8'd30},
    {15'd784, 8'd60}, {15'd0, 8'd0},
    {15'd200, 8'd200}, {15'd180, 8'd200}, {15'd160, 8'd200}, {15'd140, 8'd200},
    {15'd120, 8'd200}, {15'd0, 8'd0},
    {15'd1000, 8'd200}, {15'd500, 8'd200}, {15'd0, 8'd0}
  };

  localparam int EFFECT_START [0:NUM_EFFECTS] = '{0, 0, 4, 8, 14, 20, 26, 28, 31, 33, 43, 49};

  logic clk;
  logic rst_n;

  ptpp_req_if tone_req ();
  ptpp_res_if tone_res ();

  priority_tone_pattern_player_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (tone_req),
    .out_res (tone_res)
  );

  tone_result_t        expected_tones[$];
  logic [EFFECT_W-1:0] play_effect;
  logic [STEP_W-1:0]   play_step;
  logic [MS_W-1:0]     play_ms;
  int                  send_idle_pct;
  int                  recv_idle_pct;
  int                  error_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("priority_tone_pattern_player_core_tb: done, errors");
    $finish;
  end

  function automatic tone_step_t pattern_step(input int fx, input int st);
    int addr;
    if (fx == 0 || fx > NUM_EFFECTS || st >= MAX_STEPS || st > 15) begin
      return '0;
    end
    addr = EFFECT_START[fx] + st;
    if (addr >= ROM_DEPTH || addr >= ROM_WORDS) begin
      return '0;
    end
    return tone_step_t'(PATTERN_ROM[addr]);
  endfunction

  function automatic int pattern_length_ms(input int fx);
    int total;
    tone_step_t s;
    total = 0;
    for (int st = 0; st < 16; st++) begin
      s = pattern_step(fx, st);
      if (s.ms == 0) begin
        break;
      end
      total += int'(s.ms);
    end
    return total;
  endfunction

  function automatic void go_silent();
    play_effect = '0;
    play_step   = '0;
    play_ms     = '0;
  endfunction

  function automatic void advance_player(input logic [REQ_W-1:0] rt,
                                         input logic [EFFECT_W-1:0] fx);
    tone_step_t   cur;
    tone_result_t res;
    case (rt)
      REQ_PLAY: begin
        if (fx != 0 && fx <= NUM_EFFECTS && !(play_effect != 0 && fx > play_effect)) begin
          play_effect = fx;
          play_step   = '0;
          play_ms     = '0;
        end
      end
      REQ_STOP: begin
        go_silent();
      end
      REQ_TICK: begin
        if (play_effect != 0) begin
          if (play_ms != '1) begin
            play_ms = play_ms + 1'b1;
          end
          cur = pattern_step(play_effect, play_step);
          if (play_ms >= cur.ms) begin
            if (pattern_step(play_effect, int'(play_step) + 1).ms == 0) begin
              go_silent();
            end else begin
              play_step = play_step + 1'b1;
              play_ms   = '0;
            end
          end
        end
      end
      default: begin
      end
    endcase
    if (play_effect != 0) begin
      cur               = pattern_step(play_effect, play_step);
      res.tone_hz       = cur.hz;
      res.tone_on       = 1'b1;
      res.active_effect = play_effect;
      res.step_index    = play_step;
    end else begin
      res = '0;
    end
    expected_tones.push_back(res);
  endfunction

  task automatic send_req(input logic [REQ_W-1:0] rt, input logic [EFFECT_W-1:0] fx);
    while ($urandom_range(99) < send_idle_pct) begin
      tone_req.valid <= 1'b0;
      @(posedge clk);
    end
    tone_req.valid     <= 1'b1;
    tone_req.req_type  <= rt;
    tone_req.effect_id <= fx;
    @(posedge clk);
    while (!tone_req.ready) begin
      @(posedge clk);
    end
    advance_player(rt, fx);
  endtask

  task automatic wait_drained();
    tone_req.valid <= 1'b0;
    while (expected_tones.size() != 0) begin
      @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    out_ready_update();
  end

  task automatic out_ready_update();
    tone_res.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  endtask

  always @(posedge clk) begin
    tone_result_t exp_res;
    if (rst_n && tone_res.valid && tone_res.ready) begin
      if (expected_tones.size() == 0) begin
        $error("Result transfer arrived with nothing expected.");
        error_count++;
      end else begin
        exp_res = expected_tones.pop_front();
        if (tone_res.tone_hz !== exp_res.tone_hz) begin
          $error("tone_hz: expected %0d, actual %0d", exp_res.tone_hz, tone_res.tone_hz);
          error_count++;
        end
        if (tone_res.tone_on !== exp_res.tone_on) begin
          $error("tone_on: expected %0d, actual %0d", exp_res.tone_on, tone_res.tone_on);
          error_count++;
        end
        if (tone_res.active_effect !== exp_res.active_effect) begin
          $error("active_effect: expected %0d, actual %0d", exp_res.active_effect,
                 tone_res.active_effect);
          error_count++;
        end
        if (tone_res.step_index !== exp_res.step_index) begin
          $error("step_index: expected %0d, actual %0d", exp_res.step_index,
                 tone_res.step_index);
          error_count++;
        end
      end
    end
  end

  task automatic test_rejects_and_priority();
    send_req(REQ_PLAY, 4'd0);
    send_req(REQ_PLAY, 4'd15);
    send_req(REQ_PLAY, 4'd12);
    send_req(REQ_NOP, 4'd15);
    send_req(REQ_TICK, 4'd0);
    send_req(REQ_PLAY, 4'd11);
    send_req(REQ_PLAY, 4'd12);
    send_req(REQ_PLAY, 4'd8);
    send_req(REQ_PLAY, 4'd11);
    send_req(REQ_PLAY, 4'd8);
    send_req(REQ_NOP, 4'd0);
  endtask

  task automatic test_pattern_end();
    for (int i = 0; i < 15; i++) begin
      send_req(REQ_TICK, 4'd15);
    end
    send_req(REQ_PLAY, 4'd1);
    send_req(REQ_STOP, 4'd5);
  endtask

  task automatic test_random_patterns(input int n_items);
    int sent;
    int fx;
    int ticks;
    int r;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(99);
      if (r < 75) begin
        if ($urandom_range(3) == 0) begin
          fx = $urandom_range(NUM_EFFECTS, 1);
        end else begin
          case ($urandom_range(7))
            0: fx = 1;
            1: fx = 2;
            2: fx = 3;
            3: fx = 5;
            4: fx = 6;
            5: fx = 7;
            6: fx = 8;
            default: fx = 9;
          endcase
        end
        send_req(REQ_PLAY, 4'(fx));
        sent++;
        ticks = pattern_length_ms(fx);
        if (ticks > 300 && $urandom_range(3) != 0) begin
          ticks = $urandom_range(300, 30);
        end else if ($urandom_range(4) == 0) begin
          ticks = $urandom_range(ticks, 1);
        end else begin
          ticks = ticks + $urandom_range(3);
        end
        for (int i = 0; i < ticks; i++) begin
          r = $urandom_range(99);
          if (r < 3) begin
            send_req(REQ_PLAY, 4'($urandom_range(15)));
          end else if (r < 4) begin
            send_req(REQ_STOP, 4'($urandom_range(15)));
          end else begin
            send_req(REQ_TICK, 4'($urandom_range(15)));
          end
          sent++;
        end
      end else begin
        send_req(2'($urandom_range(3)), 4'($urandom_range(15)));
        sent++;
      end
    end
  endtask

  task automatic test_drain_pause();
    send_req(REQ_PLAY, 4'd3);
    send_req(REQ_TICK, 4'd0);
    wait_drained();
    send_req(REQ_TICK, 4'd1);
    send_req(REQ_PLAY, 4'd2);
    wait_drained();
    send_req(REQ_TICK, 4'd0);
  endtask

  initial begin
    error_count        = 0;
    send_idle_pct      = 22;
    recv_idle_pct      = 47;
    go_silent();
    rst_n              <= 1'b0;
    tone_req.valid     <= 1'b0;
    tone_req.req_type  <= REQ_TICK;
    tone_req.effect_id <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_rejects_and_priority();
    test_pattern_end();
    test_random_patterns(500);
    test_drain_pause();

    send_idle_pct = 47;
    recv_idle_pct = 22;
    test_random_patterns(500);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_patterns(500);

    wait_drained();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("priority_tone_pattern_player_core_tb: done, clean");
    end else begin
      $display("priority_tone_pattern_player_core_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== priority_tone_pattern_player_core.f =====
design/ptpp_pkg.sv
design/ptpp_if.sv
design/ptpp_in_stage.sv
design/ptpp_engine.sv
design/priority_tone_pattern_player_core.sv
sim/priority_tone_pattern_player_core_tb.sv
